// File: rtl/psrt_pkg.sv
`default_nettype none

package psrt_pkg;

    localparam int SITE_ENTRIES = 64;
    localparam int IDX_W        = (SITE_ENTRIES > 1) ? $clog2(SITE_ENTRIES) : 1;
    localparam int USED_W       = $clog2(SITE_ENTRIES + 1);

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W  = 8;
    localparam int CAP_W        = 4;
    localparam int KEY_W        = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_CAP = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_THROW_CAP = CFG_INDEX_W'(1);

    localparam logic [CAP_W-1:0] FAULT_CAP_RESET = CAP_W'(3);
    localparam logic [CAP_W-1:0] THROW_CAP_RESET = CAP_W'(8);

    localparam logic [31:0] CODE_ACCESS_VIOLATION = 32'hC000_0005;
    localparam logic [31:0] CODE_CPP_THROW        = 32'hE06D_7363;
    localparam logic [31:0] CODE_HEAP_CORRUPTION  = 32'hC000_0374;
    localparam logic [31:0] CODE_STACK_OVERFLOW   = 32'hC000_00FD;
    localparam logic [31:0] CODE_ILLEGAL_INSTR    = 32'hC000_001D;
    localparam logic [31:0] CODE_PRIV_INSTR       = 32'hC000_0096;
    localparam logic [31:0] CODE_INT_DIV_ZERO     = 32'hC000_0094;
    localparam logic [31:0] CODE_STACK_BUFFER     = 32'hC000_0409;

    localparam logic [3:0] MIN_THROW_PARAMS = 4'd3;

    localparam logic [1:0] ACT_IGNORED    = 2'd0;
    localparam logic [1:0] ACT_SUPPRESSED = 2'd1;
    localparam logic [1:0] ACT_FAULT      = 2'd2;
    localparam logic [1:0] ACT_THROW      = 2'd3;

    typedef struct packed {
        logic [31:0]      exception_code;
        logic [63:0]      fault_address;
        logic [3:0]       param_count;
        logic [63:0]      type_info_word;
    } item_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [3:0]       report_number;
        logic             mute_notice;
    } result_t;

    typedef struct packed {
        logic             watched;
        logic             thrown;
        logic [KEY_W-1:0] key;
        logic [CAP_W-1:0] cap;
    } cls_t;

    typedef struct packed {
        logic             empty;
        logic             full;
    } qstat_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CAP_W-1:0] count;
    } site_t;

endpackage

`default_nettype wire

// File: rtl/psrt_front.sv
`default_nettype none

module psrt_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire psrt_pkg::item_t                     item,
    output logic                                     busy,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [psrt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [psrt_pkg::CAP_W-1:0]          cfg_data,
    input  wire psrt_pkg::qstat_t                    q_stat,
    output logic                                     q_push,
    output psrt_pkg::cls_t                           q_wdata
);

    logic [psrt_pkg::CAP_W-1:0] fault_cap_reg;
    logic [psrt_pkg::CAP_W-1:0] throw_cap_reg;
    logic                       thrown;
    logic                       hard_fatal;

    assign cfg_ready = 1'b1;
    assign busy      = q_stat.full;
    assign q_push    = start && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_cap_reg <= psrt_pkg::FAULT_CAP_RESET;
            throw_cap_reg <= psrt_pkg::THROW_CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == psrt_pkg::CFG_FAULT_CAP)
                fault_cap_reg <= cfg_data;
            else if (cfg_index == psrt_pkg::CFG_THROW_CAP)
                throw_cap_reg <= cfg_data;
        end
    end

    always_comb
    begin
        thrown     = item.exception_code == psrt_pkg::CODE_CPP_THROW;
        hard_fatal = item.exception_code == psrt_pkg::CODE_HEAP_CORRUPTION ||
                     item.exception_code == psrt_pkg::CODE_STACK_OVERFLOW  ||
                     item.exception_code == psrt_pkg::CODE_ILLEGAL_INSTR   ||
                     item.exception_code == psrt_pkg::CODE_PRIV_INSTR      ||
                     item.exception_code == psrt_pkg::CODE_INT_DIV_ZERO    ||
                     item.exception_code == psrt_pkg::CODE_STACK_BUFFER;
        q_wdata.thrown  = thrown;
        q_wdata.watched = thrown || hard_fatal ||
                          item.exception_code == psrt_pkg::CODE_ACCESS_VIOLATION;
        q_wdata.key     = (thrown && item.param_count >= psrt_pkg::MIN_THROW_PARAMS) ?
                          item.type_info_word : item.fault_address;
        q_wdata.cap     = thrown ? throw_cap_reg : fault_cap_reg;
    end

endmodule

`default_nettype wire

// File: rtl/psrt_queue.sv
`default_nettype none

module psrt_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire psrt_pkg::cls_t     wdata,
    input  wire logic               pop,
    output psrt_pkg::cls_t          head,
    output psrt_pkg::qstat_t        stat
);

    psrt_pkg::cls_t                  slot_reg [psrt_pkg::QUEUE_DEPTH];
    logic [psrt_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [psrt_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [psrt_pkg::QCNT_W-1:0]     cnt_reg;
    logic                            do_push;
    logic                            do_pop;

    assign stat.empty = cnt_reg == '0;
    assign stat.full  = cnt_reg == psrt_pkg::QCNT_W'(psrt_pkg::QUEUE_DEPTH);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == psrt_pkg::QPTR_W'(psrt_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + psrt_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == psrt_pkg::QPTR_W'(psrt_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + psrt_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + psrt_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - psrt_pkg::QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: rtl/psrt_back.sv
`default_nettype none

module psrt_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psrt_pkg::cls_t     q_head,
    input  wire psrt_pkg::qstat_t   q_stat,
    output logic                    q_pop,
    output logic                    result_valid,
    output psrt_pkg::result_t       result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_MISS = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    psrt_pkg::cls_t                  cur_reg, cur_next;
    logic [psrt_pkg::USED_W-1:0]     idx_reg, idx_next;
    logic [psrt_pkg::USED_W-1:0]     used_reg, used_next;
    logic                            result_valid_reg, result_valid_next;
    psrt_pkg::result_t               result_reg, result_next;

    psrt_pkg::site_t                 site_mem [psrt_pkg::SITE_ENTRIES];
    psrt_pkg::site_t                 rd_data_reg;
    logic                            mem_we;
    logic [psrt_pkg::IDX_W-1:0]      mem_waddr;
    psrt_pkg::site_t                 mem_wdata;
    logic [psrt_pkg::CAP_W-1:0]      bumped;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign bumped       = rd_data_reg.count + psrt_pkg::CAP_W'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            site_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= site_mem[idx_reg[psrt_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            used_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            used_reg         <= used_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        idx_next          = idx_reg;
        used_next         = used_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        q_pop             = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg[psrt_pkg::IDX_W-1:0];
        mem_wdata         = '{key: cur_reg.key, count: bumped};

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    idx_next = '0;
                    if (!q_head.watched)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '{action: psrt_pkg::ACT_IGNORED,
                                              report_number: 4'd0, mute_notice: 1'b0};
                    end
                    else if (used_reg == '0)
                        state_next = S_MISS;
                    else
                        state_next = S_RD;
                end
            end

            S_RD:
                state_next = S_CMP;

            S_CMP:
            begin
                if (rd_data_reg.key == cur_reg.key)
                begin
                    state_next        = S_IDLE;
                    result_valid_next = 1'b1;
                    if (rd_data_reg.count >= cur_reg.cap)
                        result_next = '{action: psrt_pkg::ACT_SUPPRESSED,
                                        report_number: 4'd0, mute_notice: 1'b0};
                    else
                    begin
                        mem_we      = 1'b1;
                        result_next = '{action: cur_reg.thrown ? psrt_pkg::ACT_THROW
                                                               : psrt_pkg::ACT_FAULT,
                                        report_number: bumped,
                                        mute_notice: bumped == cur_reg.cap};
                    end
                end
                else if (idx_reg + psrt_pkg::USED_W'(1) == used_reg)
                    state_next = S_MISS;
                else
                begin
                    idx_next   = idx_reg + psrt_pkg::USED_W'(1);
                    state_next = S_RD;
                end
            end

            S_MISS:
            begin
                state_next        = S_IDLE;
                result_valid_next = 1'b1;
                if (used_reg == psrt_pkg::USED_W'(psrt_pkg::SITE_ENTRIES))
                    result_next = '{action: psrt_pkg::ACT_SUPPRESSED,
                                    report_number: 4'd0, mute_notice: 1'b0};
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = used_reg[psrt_pkg::IDX_W-1:0];
                    mem_wdata   = '{key: cur_reg.key, count: psrt_pkg::CAP_W'(1)};
                    used_next   = used_reg + psrt_pkg::USED_W'(1);
                    result_next = '{action: cur_reg.thrown ? psrt_pkg::ACT_THROW
                                                           : psrt_pkg::ACT_FAULT,
                                    report_number: 4'd1,
                                    mute_notice: cur_reg.cap == psrt_pkg::CAP_W'(1)};
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= psrt_pkg::USED_W'(psrt_pkg::SITE_ENTRIES))
        else $error("site count above table size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> idx_reg < used_reg)
        else $error("scan beyond used sites");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> state_reg == S_IDLE)
        else $error("result while scan active");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> $past(state_reg) == S_MISS)
        else $error("site insert outside miss state");

    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.action == psrt_pkg::ACT_IGNORED ||
                             result_reg.action == psrt_pkg::ACT_SUPPRESSED)
        |-> result_reg.report_number == 4'd0 && !result_reg.mute_notice)
        else $error("unreported item carries a report number");

endmodule

`default_nettype wire

// File: rtl/per_site_report_throttle.sv
`default_nettype none

// Rate limiter for exception reports, keyed per fault address or thrown type.
// Item channel: item is taken at a clock edge with start high and busy low.
// busy rises only when the two-entry queue between classifier and lookup is full.
// Result channel: result is valid for exactly one cycle while result_valid is
// high; the receiver cannot stall it, and results leave in item order.
// Config channel: cfg_index 0 writes the fault cap, 1 the throw cap (4 bits of
// cfg_data); cfg_ready is always high; other indexes are dropped.
// An ignored code is answered without a lookup. A watched item is compared with
// the sites in use (at most 64) from site 0 up and stops at the first hit, else
// it misses. The lookup scans the site memory one entry at a time through its
// single registered read port, which sets the per-item time for watched events.
// Reset clears the queue, the site count and the result strobe and restores the
// caps to 3 (fault) and 8 (throw); site memory is not cleared, as only entries
// below the site count are read.
module per_site_report_throttle (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire psrt_pkg::item_t                     item,
    output logic                                     busy,
    output logic                                     result_valid,
    output psrt_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [psrt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [psrt_pkg::CAP_W-1:0]          cfg_data
);

    psrt_pkg::qstat_t  q_stat;
    psrt_pkg::cls_t    q_wdata;
    psrt_pkg::cls_t    q_head;
    logic              q_push;
    logic              q_pop;

    psrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    psrt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    psrt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
